### rtl/pfe_pkg.sv
// shared constants, control word and status types for the playfair rectangle encipherer
package pfe_pkg;

    localparam int GRID_SIDE = 5;
    localparam int CELLS     = GRID_SIDE * GRID_SIDE;
    localparam int ALPHABET  = 26;
    localparam int LW        = 5;                     // letter code width
    localparam int RCW       = $clog2(GRID_SIDE);     // row or column width
    localparam int PW        = 2 * RCW;               // packed row/column width
    localparam int CELLW     = $clog2(CELLS);         // cell index width
    localparam int FILLW     = $clog2(CELLS + 1);     // fill counter width
    localparam int STEPW     = 5;                     // microprogram address width

    localparam logic [LW-1:0]    CODE_I       = LW'(8);
    localparam logic [LW-1:0]    CODE_J       = LW'(9);
    localparam logic [LW-1:0]    CODE_X       = LW'(23);
    localparam logic [LW-1:0]    LAST_LETTER  = LW'(ALPHABET - 1);
    localparam logic [LW-1:0]    LETTER_LIMIT = LW'(ALPHABET);
    localparam logic [FILLW-1:0] FILL_FULL    = FILLW'(CELLS);
    localparam logic [RCW-1:0]   LAST_COL     = RCW'(GRID_SIDE - 1);

    localparam logic [1:0] OP_KEY     = 2'd0;
    localparam logic [1:0] OP_FINISH  = 2'd1;
    localparam logic [1:0] OP_MESSAGE = 2'd2;

    typedef logic [STEPW-1:0] t_step;

    // microprogram addresses
    localparam t_step S_FETCH     = t_step'(0);
    localparam t_step S_DISP_KEY  = t_step'(1);
    localparam t_step S_DISP_FIN  = t_step'(2);
    localparam t_step S_DISP_MSG  = t_step'(3);
    localparam t_step S_CODE_CHK  = t_step'(4);
    localparam t_step S_PEND_CHK  = t_step'(5);
    localparam t_step S_PAIR      = t_step'(6);
    localparam t_step S_FLUSH_CHK = t_step'(7);
    localparam t_step S_FLUSH     = t_step'(8);
    localparam t_step S_KEY       = t_step'(9);
    localparam t_step S_FIN_INIT  = t_step'(10);
    localparam t_step S_FIN_LOOP  = t_step'(11);
    localparam t_step S_FIN_DONE  = t_step'(12);
    localparam t_step S_PEND_LOAD = t_step'(13);
    localparam t_step S_ENC       = t_step'(14);
    localparam t_step S_ENC_POSQ  = t_step'(15);
    localparam t_step S_ENC_CAPQ  = t_step'(16);
    localparam t_step S_ENC_LATA  = t_step'(17);
    localparam t_step S_ENC_EMA   = t_step'(18);
    localparam t_step S_ENC_EMB   = t_step'(19);

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_FETCH,
        ACT_PLACE_KEY,
        ACT_CNT_CLR,
        ACT_PLACE_CNT,
        ACT_SET_READY,
        ACT_PEND_LOAD,
        ACT_PAIR,
        ACT_FLUSH,
        ACT_RD_POS_P,
        ACT_RD_POS_Q,
        ACT_CAP_Q,
        ACT_RD_LAT_A,
        ACT_EMIT_A,
        ACT_EMIT_B
    } t_act;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ITEM,
        C_KEY,
        C_FIN,
        C_NOT_MSG,
        C_BAD_CODE,
        C_PEND_EMPTY,
        C_NO_FLUSH,
        C_CNT_MORE
    } t_cond;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_step target;
    } t_uop;

    typedef struct packed {
        logic accept;
        logic key_ok;
        logic fin_ok;
        logic not_msg;
        logic bad_code;
        logic pend_empty;
        logic no_flush;
        logic cnt_more;
        logic stall;
    } t_dp_status;

endpackage

### rtl/pfe_seq.sv
// microprogram rom, step counter and jump logic
module pfe_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pfe_pkg::t_dp_status   i_status,
    output pfe_pkg::t_act         o_act
);

    pfe_pkg::t_step r_step;
    pfe_pkg::t_step n_step;
    pfe_pkg::t_uop  w_uop;
    logic           w_take;

    always_comb begin
        case (r_step)
            pfe_pkg::S_FETCH:     w_uop = '{pfe_pkg::ACT_FETCH,     pfe_pkg::C_NO_ITEM,
                                            pfe_pkg::S_FETCH};
            pfe_pkg::S_DISP_KEY:  w_uop = '{pfe_pkg::ACT_NONE,      pfe_pkg::C_KEY,
                                            pfe_pkg::S_KEY};
            pfe_pkg::S_DISP_FIN:  w_uop = '{pfe_pkg::ACT_NONE,      pfe_pkg::C_FIN,
                                            pfe_pkg::S_FIN_INIT};
            pfe_pkg::S_DISP_MSG:  w_uop = '{pfe_pkg::ACT_NONE,      pfe_pkg::C_NOT_MSG,
                                            pfe_pkg::S_FETCH};
            pfe_pkg::S_CODE_CHK:  w_uop = '{pfe_pkg::ACT_NONE,      pfe_pkg::C_BAD_CODE,
                                            pfe_pkg::S_FLUSH_CHK};
            pfe_pkg::S_PEND_CHK:  w_uop = '{pfe_pkg::ACT_NONE,      pfe_pkg::C_PEND_EMPTY,
                                            pfe_pkg::S_PEND_LOAD};
            pfe_pkg::S_PAIR:      w_uop = '{pfe_pkg::ACT_PAIR,      pfe_pkg::C_ALWAYS,
                                            pfe_pkg::S_ENC};
            pfe_pkg::S_FLUSH_CHK: w_uop = '{pfe_pkg::ACT_NONE,      pfe_pkg::C_NO_FLUSH,
                                            pfe_pkg::S_FETCH};
            pfe_pkg::S_FLUSH:     w_uop = '{pfe_pkg::ACT_FLUSH,     pfe_pkg::C_ALWAYS,
                                            pfe_pkg::S_ENC};
            pfe_pkg::S_KEY:       w_uop = '{pfe_pkg::ACT_PLACE_KEY, pfe_pkg::C_ALWAYS,
                                            pfe_pkg::S_FETCH};
            pfe_pkg::S_FIN_INIT:  w_uop = '{pfe_pkg::ACT_CNT_CLR,   pfe_pkg::C_NEVER,
                                            pfe_pkg::S_FETCH};
            pfe_pkg::S_FIN_LOOP:  w_uop = '{pfe_pkg::ACT_PLACE_CNT, pfe_pkg::C_CNT_MORE,
                                            pfe_pkg::S_FIN_LOOP};
            pfe_pkg::S_FIN_DONE:  w_uop = '{pfe_pkg::ACT_SET_READY, pfe_pkg::C_ALWAYS,
                                            pfe_pkg::S_FETCH};
            pfe_pkg::S_PEND_LOAD: w_uop = '{pfe_pkg::ACT_PEND_LOAD, pfe_pkg::C_ALWAYS,
                                            pfe_pkg::S_FLUSH_CHK};
            pfe_pkg::S_ENC:       w_uop = '{pfe_pkg::ACT_RD_POS_P,  pfe_pkg::C_NEVER,
                                            pfe_pkg::S_FETCH};
            pfe_pkg::S_ENC_POSQ:  w_uop = '{pfe_pkg::ACT_RD_POS_Q,  pfe_pkg::C_NEVER,
                                            pfe_pkg::S_FETCH};
            pfe_pkg::S_ENC_CAPQ:  w_uop = '{pfe_pkg::ACT_CAP_Q,     pfe_pkg::C_NEVER,
                                            pfe_pkg::S_FETCH};
            pfe_pkg::S_ENC_LATA:  w_uop = '{pfe_pkg::ACT_RD_LAT_A,  pfe_pkg::C_NEVER,
                                            pfe_pkg::S_FETCH};
            pfe_pkg::S_ENC_EMA:   w_uop = '{pfe_pkg::ACT_EMIT_A,    pfe_pkg::C_NEVER,
                                            pfe_pkg::S_FETCH};
            pfe_pkg::S_ENC_EMB:   w_uop = '{pfe_pkg::ACT_EMIT_B,    pfe_pkg::C_ALWAYS,
                                            pfe_pkg::S_FLUSH_CHK};
            default:              w_uop = '{pfe_pkg::ACT_NONE,      pfe_pkg::C_ALWAYS,
                                            pfe_pkg::S_FETCH};
        endcase
    end

    always_comb begin
        case (w_uop.cond)
            pfe_pkg::C_NEVER:      w_take = 1'b0;
            pfe_pkg::C_ALWAYS:     w_take = 1'b1;
            pfe_pkg::C_NO_ITEM:    w_take = ~i_status.accept;
            pfe_pkg::C_KEY:        w_take = i_status.key_ok;
            pfe_pkg::C_FIN:        w_take = i_status.fin_ok;
            pfe_pkg::C_NOT_MSG:    w_take = i_status.not_msg;
            pfe_pkg::C_BAD_CODE:   w_take = i_status.bad_code;
            pfe_pkg::C_PEND_EMPTY: w_take = i_status.pend_empty;
            pfe_pkg::C_NO_FLUSH:   w_take = i_status.no_flush;
            pfe_pkg::C_CNT_MORE:   w_take = i_status.cnt_more;
            default:               w_take = 1'b1;
        endcase
    end

    always_comb begin
        if (i_status.stall) begin
            n_step = r_step;
        end else if (w_take) begin
            n_step = w_uop.target;
        end else begin
            n_step = r_step + pfe_pkg::t_step'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= pfe_pkg::S_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_act = w_uop.act;

endmodule

### rtl/pfe_dp.sv
// datapath: key square memories, pending letter, pair lookup and output register
module pfe_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  pfe_pkg::t_act            i_act,
    output pfe_pkg::t_dp_status      o_status,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_operation,
    input  logic [pfe_pkg::LW-1:0]   i_letter,
    input  logic                     i_message_end,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [pfe_pkg::LW-1:0]   o_cipher_letter,
    output logic                     o_run_end,
    output logic                     o_message_done
);

    // square memories
    logic [pfe_pkg::PW-1:0] r_pos_mem [pfe_pkg::ALPHABET];
    logic [pfe_pkg::LW-1:0] r_lat_mem [pfe_pkg::CELLS];
    logic [pfe_pkg::PW-1:0] r_pos_rd;
    logic [pfe_pkg::LW-1:0] r_lat_rd;

    // control state
    logic [pfe_pkg::ALPHABET-1:0] r_used,       n_used;
    logic [pfe_pkg::FILLW-1:0]    r_fill,       n_fill;
    logic [pfe_pkg::RCW-1:0]      r_row,        n_row;
    logic [pfe_pkg::RCW-1:0]      r_col,        n_col;
    logic                         r_ready,      n_ready;
    logic                         r_pend_valid, n_pend_valid;
    logic                         r_out_valid,  n_out_valid;

    // payload
    logic [1:0]               r_op,      n_op;
    logic [pfe_pkg::LW-1:0]   r_code,    n_code;
    logic                     r_code_ok, n_code_ok;
    logic                     r_last,    n_last;
    logic [pfe_pkg::LW-1:0]   r_pend,    n_pend;
    logic [pfe_pkg::LW-1:0]   r_p,       n_p;
    logic [pfe_pkg::LW-1:0]   r_q,       n_q;
    logic [pfe_pkg::LW-1:0]   r_cnt,     n_cnt;
    logic [pfe_pkg::RCW-1:0]  r_rp,      n_rp;
    logic [pfe_pkg::RCW-1:0]  r_cp,      n_cp;
    logic [pfe_pkg::RCW-1:0]  r_rq,      n_rq;
    logic [pfe_pkg::RCW-1:0]  r_cq,      n_cq;
    logic [pfe_pkg::LW-1:0]   r_out_letter, n_out_letter;
    logic                     r_out_run_end, n_out_run_end;
    logic                     r_out_done,    n_out_done;

    logic                       w_fetch;
    logic                       w_accept;
    logic                       w_emit;
    logic                       w_stall;
    logic                       w_go;
    logic                       w_place_req;
    logic                       w_place;
    logic [pfe_pkg::LW-1:0]     w_place_letter;
    logic                       w_pos_re;
    logic [pfe_pkg::LW-1:0]     w_pos_ra;
    logic                       w_lat_re;
    logic [pfe_pkg::CELLW-1:0]  w_lat_ra;
    logic                       w_final;

    assign w_fetch  = (i_act == pfe_pkg::ACT_FETCH);
    assign w_accept = i_valid & w_fetch;
    assign w_emit   = (i_act == pfe_pkg::ACT_EMIT_A) | (i_act == pfe_pkg::ACT_EMIT_B);
    assign w_stall  = w_emit & r_out_valid & ~i_ready;
    assign w_go     = ~w_stall;

    assign w_place_req    = (i_act == pfe_pkg::ACT_PLACE_KEY) | (i_act == pfe_pkg::ACT_PLACE_CNT);
    assign w_place_letter = (i_act == pfe_pkg::ACT_PLACE_CNT) ? r_cnt : r_code;
    assign w_place        = w_place_req & ~r_used[w_place_letter]
                          & (r_fill != pfe_pkg::FILL_FULL)
                          & (w_place_letter != pfe_pkg::CODE_J);

    assign w_pos_re = w_go & ((i_act == pfe_pkg::ACT_RD_POS_P) | (i_act == pfe_pkg::ACT_RD_POS_Q));
    assign w_pos_ra = (i_act == pfe_pkg::ACT_RD_POS_Q) ? r_q : r_p;

    // first letter: row of p, column of q; second: row of q, column of p
    assign w_lat_re = w_go & ((i_act == pfe_pkg::ACT_RD_LAT_A) | (i_act == pfe_pkg::ACT_EMIT_A));
    always_comb begin
        if (i_act == pfe_pkg::ACT_EMIT_A) begin
            w_lat_ra = pfe_pkg::CELLW'(r_rq) * pfe_pkg::CELLW'(pfe_pkg::GRID_SIDE)
                     + pfe_pkg::CELLW'(r_cp);
        end else begin
            w_lat_ra = pfe_pkg::CELLW'(r_rp) * pfe_pkg::CELLW'(pfe_pkg::GRID_SIDE)
                     + pfe_pkg::CELLW'(r_cq);
        end
    end

    assign w_final = ~(r_last & r_pend_valid);

    always_comb begin
        n_used        = r_used;
        n_fill        = r_fill;
        n_row         = r_row;
        n_col         = r_col;
        n_ready       = r_ready;
        n_pend_valid  = r_pend_valid;
        n_op          = r_op;
        n_code        = r_code;
        n_code_ok     = r_code_ok;
        n_last        = r_last;
        n_pend        = r_pend;
        n_p           = r_p;
        n_q           = r_q;
        n_cnt         = r_cnt;
        n_rp          = r_rp;
        n_cp          = r_cp;
        n_rq          = r_rq;
        n_cq          = r_cq;
        n_out_letter  = r_out_letter;
        n_out_run_end = r_out_run_end;
        n_out_done    = r_out_done;
        n_out_valid   = r_out_valid & ~i_ready;

        if (w_accept) begin
            n_op      = i_operation;
            n_code    = (i_letter == pfe_pkg::CODE_J) ? pfe_pkg::CODE_I : i_letter;
            n_code_ok = (i_letter < pfe_pkg::LETTER_LIMIT);
            n_last    = i_message_end;
        end

        if (w_place) begin
            n_used[w_place_letter] = 1'b1;
            n_fill = r_fill + pfe_pkg::FILLW'(1);
            if (r_col == pfe_pkg::LAST_COL) begin
                n_col = '0;
                n_row = r_row + pfe_pkg::RCW'(1);
            end else begin
                n_col = r_col + pfe_pkg::RCW'(1);
            end
        end

        if (w_go) begin
            case (i_act)
                pfe_pkg::ACT_CNT_CLR: begin
                    n_cnt = '0;
                end
                pfe_pkg::ACT_PLACE_CNT: begin
                    n_cnt = r_cnt + pfe_pkg::LW'(1);
                end
                pfe_pkg::ACT_SET_READY: begin
                    n_ready = 1'b1;
                end
                pfe_pkg::ACT_PEND_LOAD: begin
                    n_pend       = r_code;
                    n_pend_valid = 1'b1;
                end
                pfe_pkg::ACT_PAIR: begin
                    // doubled letter pairs with x and stays pending
                    n_p  = r_pend;
                    n_pend = r_code;
                    if (r_pend == r_code) begin
                        n_q = pfe_pkg::CODE_X;
                    end else begin
                        n_q          = r_code;
                        n_pend_valid = 1'b0;
                    end
                end
                pfe_pkg::ACT_FLUSH: begin
                    n_p          = r_pend;
                    n_q          = pfe_pkg::CODE_X;
                    n_pend_valid = 1'b0;
                end
                pfe_pkg::ACT_RD_POS_Q: begin
                    n_rp = r_pos_rd[pfe_pkg::PW-1:pfe_pkg::RCW];
                    n_cp = r_pos_rd[pfe_pkg::RCW-1:0];
                end
                pfe_pkg::ACT_CAP_Q: begin
                    n_rq = r_pos_rd[pfe_pkg::PW-1:pfe_pkg::RCW];
                    n_cq = r_pos_rd[pfe_pkg::RCW-1:0];
                end
                pfe_pkg::ACT_EMIT_A: begin
                    n_out_valid   = 1'b1;
                    n_out_letter  = r_lat_rd;
                    n_out_run_end = 1'b0;
                    n_out_done    = 1'b0;
                end
                pfe_pkg::ACT_EMIT_B: begin
                    n_out_valid   = 1'b1;
                    n_out_letter  = r_lat_rd;
                    n_out_run_end = w_final;
                    n_out_done    = w_final & r_last;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= '0;
            r_fill       <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_ready      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_used       <= n_used;
            r_fill       <= n_fill;
            r_row        <= n_row;
            r_col        <= n_col;
            r_ready      <= n_ready;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_code        <= n_code;
        r_code_ok     <= n_code_ok;
        r_last        <= n_last;
        r_pend        <= n_pend;
        r_p           <= n_p;
        r_q           <= n_q;
        r_cnt         <= n_cnt;
        r_rp          <= n_rp;
        r_cp          <= n_cp;
        r_rq          <= n_rq;
        r_cq          <= n_cq;
        r_out_letter  <= n_out_letter;
        r_out_run_end <= n_out_run_end;
        r_out_done    <= n_out_done;
    end

    always_ff @(posedge i_clk) begin
        if (w_place) begin
            r_pos_mem[w_place_letter]                <= {r_row, r_col};
            r_lat_mem[r_fill[pfe_pkg::CELLW-1:0]]   <= w_place_letter;
        end
        if (w_pos_re) begin
            r_pos_rd <= r_pos_mem[w_pos_ra];
        end
        if (w_lat_re) begin
            r_lat_rd <= r_lat_mem[w_lat_ra];
        end
    end

    assign o_status.accept     = w_accept;
    assign o_status.key_ok     = (r_op == pfe_pkg::OP_KEY) & ~r_ready & r_code_ok;
    assign o_status.fin_ok     = (r_op == pfe_pkg::OP_FINISH) & ~r_ready;
    assign o_status.not_msg    = ~((r_op == pfe_pkg::OP_MESSAGE) & r_ready);
    assign o_status.bad_code   = ~r_code_ok;
    assign o_status.pend_empty = ~r_pend_valid;
    assign o_status.no_flush   = ~(r_last & r_pend_valid);
    assign o_status.cnt_more   = (r_cnt != pfe_pkg::LAST_LETTER);
    assign o_status.stall      = w_stall;

    assign o_ready         = w_fetch;
    assign o_valid         = r_out_valid;
    assign o_cipher_letter = r_out_letter;
    assign o_run_end       = r_out_run_end;
    assign o_message_done  = r_out_done;

endmodule

### rtl/playfair_rectangle_encipher.sv
// top level of the playfair key square builder and rectangle-rule encipherer
// input channel (i_valid / o_ready): one transaction carries i_operation,
// i_letter and i_message_end. keyword letters build the 5x5 square with
// repeats skipped, a finish transaction fills the rest alphabetically
// (j folded to i), then message letters are paired and enciphered.
// output channel (o_valid / i_ready): one cipher letter per transaction;
// o_run_end marks the last letter caused by an input transaction and
// o_message_done the final letter of the message.
// a microprogram steps through each transaction; o_ready is high only in
// the fetch step, so one input transaction is worked on at a time.
// a finish transaction walks the alphabet, one step per letter; each pair
// costs two position reads and two square reads.
// reset (synchronous, active low) empties the square and the pending letter.
// a stalled receiver holds the last cipher letter in the output register;
// the sequencer stops only when it must load a new letter, and the next
// input transaction can still be taken while a letter waits.
module playfair_rectangle_encipher (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_operation,
    input  logic [pfe_pkg::LW-1:0]   i_letter,
    input  logic                     i_message_end,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [pfe_pkg::LW-1:0]   o_cipher_letter,
    output logic                     o_run_end,
    output logic                     o_message_done
);

    // control word action from the rom, status back for jumps and stalls
    pfe_pkg::t_act       w_act;
    pfe_pkg::t_dp_status w_status;

    pfe_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_act    (w_act)
    );

    pfe_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_act           (w_act),
        .o_status        (w_status),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_letter        (i_letter),
        .i_message_end   (i_message_end),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_cipher_letter (o_cipher_letter),
        .o_run_end       (o_run_end),
        .o_message_done  (o_message_done)
    );

endmodule

### rtl/pfe_checker.sv
// port-level checker for the encipherer and its bind to the top level
module pfe_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_ready,
    input logic [1:0]               i_operation,
    input logic [pfe_pkg::LW-1:0]   i_letter,
    input logic                     i_message_end,
    input logic                     o_valid,
    input logic                     i_ready,
    input logic [pfe_pkg::LW-1:0]   o_cipher_letter,
    input logic                     o_run_end,
    input logic                     o_message_done
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_cipher_letter)
            && $stable(o_run_end) && $stable(o_message_done))
        else $error("output transaction changed while stalled");

    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_message_done |-> o_run_end)
        else $error("message end without run end");

    a_letter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cipher_letter <= pfe_pkg::LAST_LETTER)
            && (o_cipher_letter != pfe_pkg::CODE_J))
        else $error("cipher letter out of range or j");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_key_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_operation == pfe_pkg::OP_KEY) && !o_valid |=> !o_valid)
        else $error("keyword transaction produced output");

endmodule

bind playfair_rectangle_encipher pfe_checker u_pfe_checker (.*);

### verif/playfair_rectangle_encipher_test.sv
// testbench for the playfair rectangle encipherer: directed table, then random letter streams
module playfair_rectangle_encipher_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 235;     // message letters in the random part
    localparam int NOISE_PCT    = 8;       // share of ignored or malformed transactions
    localparam int MAX_MSG_LEN  = 12;
    localparam int TAIL_CYCLES  = 40;      // longer than a finish walk or a lone letter
    localparam int CYCLE_LIMIT  = 200000;

    // operation code the block has no use for
    localparam logic [1:0] OP_SPARE = 2'd3;

    // letter codes used by the directed table
    localparam logic [pfe_pkg::LW-1:0] CODE_A    = pfe_pkg::LW'(0);
    localparam logic [pfe_pkg::LW-1:0] CODE_B    = pfe_pkg::LW'(1);
    localparam logic [pfe_pkg::LW-1:0] CODE_E    = pfe_pkg::LW'(4);
    localparam logic [pfe_pkg::LW-1:0] CODE_H    = pfe_pkg::LW'(7);
    localparam logic [pfe_pkg::LW-1:0] CODE_L    = pfe_pkg::LW'(11);
    localparam logic [pfe_pkg::LW-1:0] CODE_O    = pfe_pkg::LW'(14);
    localparam logic [pfe_pkg::LW-1:0] CODE_P    = pfe_pkg::LW'(15);
    localparam logic [pfe_pkg::LW-1:0] CODE_Q    = pfe_pkg::LW'(16);
    localparam logic [pfe_pkg::LW-1:0] CODE_Y    = pfe_pkg::LW'(24);
    localparam logic [pfe_pkg::LW-1:0] CODE_ONES = '1;       // all bits set, no letter

    // how a transaction's cipher letters are worked out
    typedef enum logic [1:0] {
        CHK_MODEL,      // from the square predictor
        CHK_NONE,       // ignored or silent, no cipher letter at all
        CHK_ALL_X       // a run of x letters, count given in the row
    } t_chk_kind;

    typedef struct packed {
        logic [pfe_pkg::LW-1:0] letter;
        logic                   run_end;
        logic                   done;
    } t_cipher;

    typedef struct packed {
        logic [1:0]             op;
        logic [pfe_pkg::LW-1:0] letter;
        logic                   last;
        t_chk_kind              kind;
        logic [2:0]             x_count;
    } t_row;

    localparam int DIRECTED_ROWS = 26;

    localparam t_row DIRECTED [DIRECTED_ROWS] = '{
        // square not built yet: message letter and its end marker are dropped
        '{pfe_pkg::OP_MESSAGE, CODE_A,                1'b1, CHK_NONE,  3'd0},
        '{OP_SPARE,            CODE_ONES,             1'b1, CHK_NONE,  3'd0},
        // keyword with a repeat, j folded onto i, codes past z
        '{pfe_pkg::OP_KEY,     CODE_P,                1'b0, CHK_NONE,  3'd0},
        '{pfe_pkg::OP_KEY,     CODE_L,                1'b0, CHK_NONE,  3'd0},
        '{pfe_pkg::OP_KEY,     CODE_A,                1'b0, CHK_NONE,  3'd0},
        '{pfe_pkg::OP_KEY,     CODE_Y,                1'b0, CHK_NONE,  3'd0},
        '{pfe_pkg::OP_KEY,     CODE_A,                1'b0, CHK_NONE,  3'd0},
        '{pfe_pkg::OP_KEY,     pfe_pkg::CODE_J,       1'b0, CHK_NONE,  3'd0},
        '{pfe_pkg::OP_KEY,     pfe_pkg::CODE_I,       1'b0, CHK_NONE,  3'd0},
        '{pfe_pkg::OP_KEY,     CODE_ONES,             1'b0, CHK_NONE,  3'd0},
        '{pfe_pkg::OP_KEY,     pfe_pkg::LAST_LETTER,  1'b0, CHK_NONE,  3'd0},
        '{pfe_pkg::OP_KEY,     pfe_pkg::LETTER_LIMIT, 1'b1, CHK_NONE,  3'd0},
        '{pfe_pkg::OP_FINISH,  CODE_A,                1'b0, CHK_NONE,  3'd0},
        // square is frozen now: a second finish and late keyword letters do nothing
        '{pfe_pkg::OP_FINISH,  pfe_pkg::LAST_LETTER,  1'b1, CHK_NONE,  3'd0},
        '{pfe_pkg::OP_KEY,     CODE_B,                1'b0, CHK_NONE,  3'd0},
        // plain pair, then a doubled letter that gets x inserted
        '{pfe_pkg::OP_MESSAGE, CODE_H,                1'b0, CHK_MODEL, 3'd0},
        '{pfe_pkg::OP_MESSAGE, CODE_E,                1'b0, CHK_MODEL, 3'd0},
        '{pfe_pkg::OP_MESSAGE, CODE_L,                1'b0, CHK_MODEL, 3'd0},
        '{pfe_pkg::OP_MESSAGE, CODE_L,                1'b0, CHK_MODEL, 3'd0},
        '{pfe_pkg::OP_MESSAGE, CODE_O,                1'b1, CHK_MODEL, 3'd0},
        // x doubled and then flushed with x: four x letters
        '{pfe_pkg::OP_MESSAGE, pfe_pkg::CODE_X,       1'b0, CHK_MODEL, 3'd0},
        '{pfe_pkg::OP_MESSAGE, pfe_pkg::CODE_X,       1'b1, CHK_ALL_X, 3'd4},
        // lone letter padded at the end
        '{pfe_pkg::OP_MESSAGE, CODE_Q,                1'b1, CHK_MODEL, 3'd0},
        // end marker with nothing pending and a bad code: silent
        '{pfe_pkg::OP_MESSAGE, CODE_ONES,             1'b1, CHK_NONE,  3'd0},
        // j in the message, then a bad code whose end marker flushes it
        '{pfe_pkg::OP_MESSAGE, pfe_pkg::CODE_J,       1'b0, CHK_MODEL, 3'd0},
        '{pfe_pkg::OP_MESSAGE, pfe_pkg::LETTER_LIMIT, 1'b1, CHK_MODEL, 3'd0}
    };

    // block ports
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_valid       = 1'b0;
    logic                   o_ready;
    logic [1:0]             i_operation   = OP_SPARE;
    logic [pfe_pkg::LW-1:0] i_letter      = '0;
    logic                   i_message_end = 1'b0;
    logic                   o_valid;
    logic                   i_ready       = 1'b0;
    logic [pfe_pkg::LW-1:0] o_cipher_letter;
    logic                   o_run_end;
    logic                   o_message_done;

    // how the transaction on the input port is to be checked, moves with the payload
    t_chk_kind   cur_kind    = CHK_MODEL;
    logic [2:0]  cur_x_count = '0;

    // idling of both sides, in percent of cycles
    int send_idle  = 0;
    int recv_stall = 0;

    int mismatches  = 0;
    int cycle_count = 0;

    // predicted square and pairing state
    logic [pfe_pkg::CELLW-1:0] cell_of_letter [pfe_pkg::ALPHABET];
    logic [pfe_pkg::LW-1:0]    square_cell    [pfe_pkg::CELLS];
    logic                      letter_placed  [pfe_pkg::ALPHABET];
    int                        cells_filled   = 0;
    logic                      square_done    = 1'b0;
    logic [pfe_pkg::LW-1:0]    held_letter    = '0;
    logic                      held_valid     = 1'b0;

    t_cipher cipher_due [$];     // cipher letters still to come, oldest first
    t_cipher item_ciphers [$];   // cipher letters of the transaction being predicted

    playfair_rectangle_encipher u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_letter        (i_letter),
        .i_message_end   (i_message_end),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_cipher_letter (o_cipher_letter),
        .o_run_end       (o_run_end),
        .o_message_done  (o_message_done)
    );

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // receiver: stalls at random according to the current phase
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // appends to the letters of the transaction being predicted
    function automatic void add_item_cipher(input t_cipher c);
        item_ciphers = {item_ciphers, c};
    endfunction

    // appends to the letters still expected from the block
    function automatic void add_due(input t_cipher c);
        cipher_due = {cipher_due, c};
    endfunction

    // a letter goes into the next free cell unless it is already in the square or the square is full
    function automatic void place_in_square(input logic [pfe_pkg::LW-1:0] code);
        if (!letter_placed[code] && cells_filled < pfe_pkg::CELLS) begin
            letter_placed[code]         = 1'b1;
            cell_of_letter[code]        = pfe_pkg::CELLW'(cells_filled);
            square_cell[cells_filled]   = code;
            cells_filled                = cells_filled + 1;
        end
    endfunction

    // rectangle corner: row of the first letter, column of the second
    function automatic logic [pfe_pkg::LW-1:0] corner_letter(
            input logic [pfe_pkg::LW-1:0] row_from,
            input logic [pfe_pkg::LW-1:0] col_from);
        int row;
        int col;
        row = int'(cell_of_letter[row_from]) / pfe_pkg::GRID_SIDE;
        col = int'(cell_of_letter[col_from]) % pfe_pkg::GRID_SIDE;
        return square_cell[row * pfe_pkg::GRID_SIDE + col];
    endfunction

    function automatic void add_pair(input logic [pfe_pkg::LW-1:0] p,
                                     input logic [pfe_pkg::LW-1:0] q);
        add_item_cipher('{corner_letter(p, q), 1'b0, 1'b0});
        add_item_cipher('{corner_letter(q, p), 1'b0, 1'b0});
    endfunction

    // updates the predicted state for one accepted transaction and queues its letters
    task automatic predict_cipher(input logic [1:0]             op,
                                  input logic [pfe_pkg::LW-1:0] raw,
                                  input logic                   last,
                                  input t_chk_kind              kind,
                                  input logic [2:0]             x_count);
        logic [pfe_pkg::LW-1:0] code;
        logic                   code_ok;
        int                     c;
        int                     n;
        item_ciphers.delete();
        code_ok = (raw < pfe_pkg::LETTER_LIMIT);
        code    = (raw == pfe_pkg::CODE_J) ? pfe_pkg::CODE_I : raw;
        case (op)
            pfe_pkg::OP_KEY: begin
                if (!square_done && code_ok)
                    place_in_square(code);
            end
            pfe_pkg::OP_FINISH: begin
                // fill the free cells alphabetically, j never gets a cell
                if (!square_done) begin
                    for (c = 0; c < pfe_pkg::ALPHABET; c++)
                        if (pfe_pkg::LW'(c) != pfe_pkg::CODE_J)
                            place_in_square(pfe_pkg::LW'(c));
                    square_done = 1'b1;
                end
            end
            pfe_pkg::OP_MESSAGE: begin
                if (square_done) begin
                    if (code_ok) begin
                        if (!held_valid) begin
                            held_letter = code;
                            held_valid  = 1'b1;
                        end else if (held_letter == code) begin
                            // doubled letter: pair with x, the new one stays held
                            add_pair(held_letter, pfe_pkg::CODE_X);
                        end else begin
                            add_pair(held_letter, code);
                            held_valid = 1'b0;
                        end
                    end
                    if (last && held_valid) begin
                        add_pair(held_letter, pfe_pkg::CODE_X);
                        held_valid = 1'b0;
                    end
                    if (last && item_ciphers.size() > 0)
                        item_ciphers[item_ciphers.size() - 1].done = 1'b1;
                end
            end
            default: begin
            end
        endcase
        n = item_ciphers.size();
        if (n > 0)
            item_ciphers[n - 1].run_end = 1'b1;
        if (kind == CHK_MODEL) begin
            foreach (item_ciphers[k])
                add_due(item_ciphers[k]);
        end else begin
            for (c = 0; c < int'(x_count); c++)
                add_due('{pfe_pkg::CODE_X, c == int'(x_count) - 1,
                          last && (c == int'(x_count) - 1)});
        end
    endtask

    // scoreboard: predict on each input transaction, check each output transaction
    always @(posedge i_clk) begin : watch
        t_cipher got;
        t_cipher want;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                predict_cipher(i_operation, i_letter, i_message_end, cur_kind, cur_x_count);
            if (o_valid && i_ready) begin
                got = '{o_cipher_letter, o_run_end, o_message_done};
                if (cipher_due.size() == 0) begin
                    $display("%0t: unexpected cipher letter, expected none, actual %0d/%0b/%0b",
                             $time, got.letter, got.run_end, got.done);
                    mismatches++;
                end else begin
                    want = cipher_due.pop_front();
                    if (got.letter !== want.letter) begin
                        $display("%0t: cipher_letter expected %0d actual %0d",
                                 $time, want.letter, got.letter);
                        mismatches++;
                    end
                    if (got.run_end !== want.run_end) begin
                        $display("%0t: run_end expected %0b actual %0b",
                                 $time, want.run_end, got.run_end);
                        mismatches++;
                    end
                    if (got.done !== want.done) begin
                        $display("%0t: message_done expected %0b actual %0b",
                                 $time, want.done, got.done);
                        mismatches++;
                    end
                end
            end
        end
    end

    // called at the edge where the previous transaction went in; returns at the
    // edge where this one is taken
    task automatic put_item(input logic [1:0]             op,
                            input logic [pfe_pkg::LW-1:0] letter,
                            input logic                   last,
                            input t_chk_kind              kind,
                            input logic [2:0]             x_count);
        if ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle)
                @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_letter      <= letter;
        i_message_end <= last;
        cur_kind      <= kind;
        cur_x_count   <= x_count;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    initial begin
        int                     msg_items;
        int                     msg_left;
        int                     roll;
        logic [1:0]             op;
        logic [pfe_pkg::LW-1:0] letter;
        logic [pfe_pkg::LW-1:0] prev_letter;
        logic                   last;

        msg_items   = 0;
        msg_left    = 0;
        prev_letter = CODE_A;
        foreach (letter_placed[k])
            letter_placed[k] = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, no idling
        for (int r = 0; r < DIRECTED_ROWS; r++)
            put_item(DIRECTED[r].op, DIRECTED[r].letter, DIRECTED[r].last,
                     DIRECTED[r].kind, DIRECTED[r].x_count);

        // random messages on the finished square, sprinkled with noise
        while (msg_items < RANDOM_ITEMS) begin
            case (msg_items * 4 / RANDOM_ITEMS)
                0:       begin send_idle = 0;  recv_stall = 0;  end
                1:       begin send_idle = 65; recv_stall = 0;  end
                2:       begin send_idle = 0;  recv_stall = 65; end
                default: begin send_idle = 7;  recv_stall = 7;  end
            endcase
            if ($urandom_range(99) < NOISE_PCT) begin
                letter = pfe_pkg::LW'($urandom_range(31));
                last   = 1'($urandom_range(1));
                case ($urandom_range(3))
                    0:       op = OP_SPARE;
                    1:       op = pfe_pkg::OP_KEY;
                    2:       op = pfe_pkg::OP_FINISH;
                    default: begin
                        // bad code inside a message, its end marker still counts
                        op     = pfe_pkg::OP_MESSAGE;
                        letter = pfe_pkg::LW'($urandom_range(31, pfe_pkg::ALPHABET));
                        if (last)
                            msg_left = 0;
                    end
                endcase
            end else begin
                if (msg_left == 0)
                    msg_left = $urandom_range(MAX_MSG_LEN, 1);
                roll = $urandom_range(99);
                if (roll < 20)
                    letter = prev_letter;           // forces doubled letters
                else if (roll < 30)
                    letter = pfe_pkg::CODE_X;
                else
                    letter = pfe_pkg::LW'($urandom_range(pfe_pkg::ALPHABET - 1));
                op          = pfe_pkg::OP_MESSAGE;
                msg_left    = msg_left - 1;
                last        = (msg_left == 0);
                prev_letter = letter;
                msg_items++;
            end
            put_item(op, letter, last, CHK_MODEL, 3'd0);
        end
        i_valid <= 1'b0;

        // drain, then give a lingering late letter time to show up
        while (cipher_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && cipher_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
